### rtl/bcc_pkg.sv
package bcc_pkg;

	localparam int IDX_W      = 5;
	localparam int CNT_W      = 8;
	localparam int PAR_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [PAR_W-1:0] LONG_MIN_RST = 16'd400;
	localparam logic [PAR_W-1:0] GAP_MAX_RST  = 16'd500;
	localparam logic [PAR_W-1:0] TIMEOUT_RST  = 16'd500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLED  = 2'd0,
		REG_LONG_MIN = 2'd1,
		REG_GAP_MAX  = 2'd2,
		REG_TIMEOUT  = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		EVT_SEQUENCE = 1'b0,
		EVT_LONG     = 1'b1
	} evt_kind_t;

	typedef struct packed {
		logic [PAR_W-1:0] long_min;
		logic [PAR_W-1:0] gap_max;
		logic [PAR_W-1:0] timeout;
	} timing_cfg_t;

	// events one lane raises in one pass: timeout report first, then long press
	typedef struct packed {
		logic             tmo;
		logic             lng;
		logic [CNT_W-1:0] tmo_cnt;
		logic [CNT_W-1:0] lng_cnt;
	} lane_evt_t;

endpackage

### rtl/bcc_if.sv
interface bcc_in_if #(
	parameter int NUM_BUTTONS = 24,
	parameter int TIME_WIDTH  = 32
) ();
	logic                   valid;
	logic                   ready;
	logic [TIME_WIDTH-1:0]  time_now;
	logic [NUM_BUTTONS-1:0] pin_levels;
	logic [NUM_BUTTONS-1:0] lock_mask;

	modport source (output valid, time_now, pin_levels, lock_mask, input ready);
	modport sink   (input valid, time_now, pin_levels, lock_mask, output ready);
endinterface

interface bcc_out_if import bcc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] button_index;
	logic             event_kind;
	logic [CNT_W-1:0] click_count;
	logic             last_event;

	modport source (output valid, button_index, event_kind, click_count, last_event,
		input ready);
	modport sink   (input valid, button_index, event_kind, click_count, last_event,
		output ready);
endinterface

interface bcc_cfg_if import bcc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/bcc_lane.sv
module bcc_lane import bcc_pkg::*; #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic                  enabled,
	input  logic                  lock,
	input  logic                  pin,
	input  logic [TIME_WIDTH-1:0] now,
	input  timing_cfg_t           tcfg,
	output lane_evt_t             evt
);

	logic                  level_q, level_n;
	logic [TIME_WIDTH-1:0] press_q, press_n;
	logic [TIME_WIDTH-1:0] lsr_q, lsr_n;
	logic [TIME_WIDTH-1:0] dl_q, dl_n;
	logic [CNT_W-1:0]      clicks_q, clicks_n;

	logic                  tmo;
	logic [CNT_W-1:0]      clicks1;
	logic [TIME_WIDTH-1:0] press1;
	logic [TIME_WIDTH-1:0] dl1;
	logic [TIME_WIDTH-1:0] held;
	logic [TIME_WIDTH-1:0] lsr_eff;
	logic [TIME_WIDTH-1:0] gap;

	// deadline compare ignores wrap; zero means nothing pending
	assign tmo     = (dl_q != '0) && (now > dl_q);
	assign clicks1 = tmo ? '0 : clicks_q;
	assign press1  = tmo ? '0 : press_q;
	assign dl1     = tmo ? '0 : dl_q;
	assign held    = now - press1;
	assign lsr_eff = (clicks1 == '0) ? now : lsr_q;
	assign gap     = now - lsr_eff;

	always_comb begin
		level_n  = level_q;
		press_n  = press_q;
		lsr_n    = lsr_q;
		dl_n     = dl_q;
		clicks_n = clicks_q;
		evt      = '0;
		if (enabled) begin
			if (lock) begin
				dl_n     = '0;
				press_n  = '0;
				clicks_n = '0;
				level_n  = 1'b1;
			end else begin
				evt.tmo     = tmo;
				evt.tmo_cnt = clicks_q;
				dl_n        = dl1;
				press_n     = press1;
				clicks_n    = clicks1;
				if (pin != level_q) begin
					level_n = pin;
					if (!pin) begin
						dl_n    = '0;
						press_n = now;
					end else if (held < TIME_WIDTH'(tcfg.long_min)) begin
						dl_n     = now + TIME_WIDTH'(tcfg.timeout);
						clicks_n = (gap > TIME_WIDTH'(tcfg.gap_max)) ? CNT_W'(1)
							: clicks1 + CNT_W'(1);
						lsr_n    = now;
					end else begin
						evt.lng     = 1'b1;
						evt.lng_cnt = clicks1;
						dl_n        = '0;
						press_n     = '0;
						clicks_n    = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= 1'b1;
			press_q  <= '0;
			lsr_q    <= '0;
			dl_q     <= '0;
			clicks_q <= '0;
		end else if (load) begin
			level_q  <= level_n;
			press_q  <= press_n;
			lsr_q    <= lsr_n;
			dl_q     <= dl_n;
			clicks_q <= clicks_n;
		end
	end

endmodule

### rtl/bcc_merge.sv
module bcc_merge import bcc_pkg::*; #(
	parameter int NUM_BUTTONS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  lane_evt_t evt [NUM_BUTTONS],
	output logic      free,
	bcc_out_if.source out_ch
);

	localparam int SLOTS = 2 * NUM_BUTTONS;
	localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	// slot 2b is button b's timeout report, slot 2b+1 its long press
	logic [SLOTS-1:0] pend_q;
	logic [SLOTS-1:0] new_pend;
	logic [SLOTS-1:0] sel;
	logic [SLOTS-1:0] rest;
	logic [SLOTS-1:0] odd_mask;
	logic [CNT_W-1:0] tmo_cnt_q [NUM_BUTTONS];
	logic [CNT_W-1:0] lng_cnt_q [NUM_BUTTONS];
	logic [BTN_W-1:0] btn_sel;
	logic             kind_sel;
	logic             take;
	logic             out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	logic             out_kind_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             out_last_q;

	always_comb begin
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			new_pend[2*b]   = evt[b].tmo;
			new_pend[2*b+1] = evt[b].lng;
			odd_mask[2*b]   = 1'b0;
			odd_mask[2*b+1] = 1'b1;
		end
	end

	assign sel      = pend_q & (~pend_q + SLOTS'(1));
	assign rest     = pend_q & ~sel;
	assign kind_sel = |(sel & odd_mask);
	assign take     = (pend_q != '0) && (!out_valid_q || out_ch.ready);
	assign free     = take ? (rest == '0) : (pend_q == '0);

	always_comb begin
		btn_sel = '0;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			if (sel[2*b] || sel[2*b+1]) begin
				btn_sel = btn_sel | BTN_W'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= new_pend;
		end else if (take) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				tmo_cnt_q[b] <= evt[b].tmo_cnt;
				lng_cnt_q[b] <= evt[b].lng_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_idx_q  <= IDX_W'(btn_sel);
			out_kind_q <= kind_sel;
			out_cnt_q  <= kind_sel ? lng_cnt_q[btn_sel] : tmo_cnt_q[btn_sel];
			out_last_q <= (rest == '0);
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.button_index = out_idx_q;
	assign out_ch.event_kind   = out_kind_q;
	assign out_ch.click_count  = out_cnt_q;
	assign out_ch.last_event   = out_last_q;

endmodule

### rtl/button_click_classifier_unit.sv
// channel  dir  handshake      payload
// in_ch    in   valid/ready    time_now, pin_levels, lock_mask (one polling pass)
// out_ch   out  valid/ready    button_index, event_kind, click_count, last_event
// cfg_ch   in   valid/ready    index, data (ready always high)
//
// A pass is registered in the input stage; once the merge buffer is free, all
// button lanes resolve it together and park their events in the merge buffer.
// The merge stage hands out one event per cycle while the output is not stalled,
// lowest button first. The next pass enters the lanes as the last event of the
// current one is taken from the buffer; a silent pass holds back no other pass.
// Up to NUM_BUTTONS events per pass (a button raises at most one); output
// register decouples stalls.
// arst_n clears all button state and the config registers to their defaults.
module button_click_classifier_unit import bcc_pkg::*; #(
	parameter int NUM_BUTTONS = 24,
	parameter int TIME_WIDTH  = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	bcc_in_if.sink    in_ch,
	bcc_out_if.source out_ch,
	bcc_cfg_if.sink   cfg_ch
);

	logic                   valid_s1;
	logic [TIME_WIDTH-1:0]  time_s1;
	logic [NUM_BUTTONS-1:0] pins_s1;
	logic [NUM_BUTTONS-1:0] lock_s1;
	logic                   free;
	logic                   advance;

	logic [NUM_BUTTONS-1:0] enabled_q;
	timing_cfg_t            tcfg_q;
	lane_evt_t              evt [NUM_BUTTONS];

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q       <= '0;
			tcfg_q.long_min <= LONG_MIN_RST;
			tcfg_q.gap_max  <= GAP_MAX_RST;
			tcfg_q.timeout  <= TIMEOUT_RST;
		end else if (cfg_ch.valid) begin
			unique case (cfg_reg_t'(cfg_ch.index))
				REG_ENABLED:  enabled_q       <= cfg_ch.data[NUM_BUTTONS-1:0];
				REG_LONG_MIN: tcfg_q.long_min <= cfg_ch.data[PAR_W-1:0];
				REG_GAP_MAX:  tcfg_q.gap_max  <= cfg_ch.data[PAR_W-1:0];
				REG_TIMEOUT:  tcfg_q.timeout  <= cfg_ch.data[PAR_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance     = valid_s1 && free;
	assign in_ch.ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			time_s1 <= in_ch.time_now;
			pins_s1 <= in_ch.pin_levels;
			lock_s1 <= in_ch.lock_mask;
		end
	end

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
		bcc_lane #(
			.TIME_WIDTH(TIME_WIDTH)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (advance),
			.enabled (enabled_q[b]),
			.lock    (lock_s1[b]),
			.pin     (pins_s1[b]),
			.now     (time_s1),
			.tcfg    (tcfg_q),
			.evt     (evt[b])
		);
	end

	bcc_merge #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.evt    (evt),
		.free   (free),
		.out_ch (out_ch)
	);

endmodule

### rtl/bcc_check.sv
module bcc_check import bcc_pkg::*; #(
	parameter int NUM_BUTTONS = 24
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [IDX_W-1:0] out_index,
	input logic             out_kind,
	input logic             out_last
);

	logic             seen_q;
	logic             mid_q;
	logic [IDX_W-1:0] pidx_q;
	logic             pkind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			mid_q   <= 1'b0;
			pidx_q  <= '0;
			pkind_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				seen_q <= 1'b1;
			end
			if (out_valid && out_ready) begin
				mid_q   <= !out_last;
				pidx_q  <= out_index;
				pkind_q <= out_kind;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_index < NUM_BUTTONS)
		else $error("button index out of range");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && mid_q |-> {out_index, out_kind} > {pidx_q, pkind_q})
		else $error("events of one pass out of order");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_q)
		else $error("result without any accepted item");

endmodule

bind button_click_classifier_unit bcc_check #(
	.NUM_BUTTONS(NUM_BUTTONS)
) u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_index (out_ch.button_index),
	.out_kind  (out_ch.event_kind),
	.out_last  (out_ch.last_event)
);

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import bcc_pkg::*;

	localparam int NB        = 24;
	localparam int TW        = 32;
	localparam int SETTLE    = 2 * NB + 12;
	localparam int QUIET_MAX = 3000;

	typedef struct {
		logic [TW-1:0] t;
		logic [NB-1:0] pins;
		logic [NB-1:0] lock;
	} poll_t;

	typedef struct {
		logic [IDX_W-1:0] idx;
		evt_kind_t        kind;
		logic [CNT_W-1:0] count;
		logic             last;
	} btn_event_t;

	logic clk = 1'b0;
	logic arst_n;

	bcc_in_if #(.NUM_BUTTONS(NB), .TIME_WIDTH(TW)) in_ch ();
	bcc_out_if out_ch ();
	bcc_cfg_if cfg_ch ();

	button_click_classifier_unit #(
		.NUM_BUTTONS(NB),
		.TIME_WIDTH (TW)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	always #10 clk = ~clk;

	// shadow of the block's registers and per-button state
	logic [NB-1:0]    en_mask;
	logic [PAR_W-1:0] long_min;
	logic [PAR_W-1:0] gap_max;
	logic [PAR_W-1:0] seq_tmo;
	logic             level [NB];
	logic [TW-1:0]    press_t [NB];
	logic [TW-1:0]    last_rel [NB];
	logic [TW-1:0]    deadline [NB];
	logic [CNT_W-1:0] clicks [NB];

	poll_t      polls_q [$];
	btn_event_t events_due [$];
	btn_event_t staged;
	bit         have_staged;

	logic [TW-1:0] stim_t;
	logic [NB-1:0] stim_pins;

	bit         in_acc;
	bit         out_acc;
	poll_t      nxt_poll;
	btn_event_t want;
	int         gap_left;
	int         burst_left;
	int         stall_cyc;
	int         stall_mode;
	int         quiet;
	int         errors;

	function automatic void apply_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
		case (r)
			REG_ENABLED:  en_mask = d[NB-1:0];
			REG_LONG_MIN: long_min = d[PAR_W-1:0];
			REG_GAP_MAX:  gap_max = d[PAR_W-1:0];
			REG_TIMEOUT:  seq_tmo = d[PAR_W-1:0];
		endcase
	endfunction

	function automatic void clear_seq(int b);
		deadline[b] = '0;
		press_t[b] = '0;
		clicks[b] = '0;
	endfunction

	// events of one pass are held back by one so the final one can be marked
	function automatic void stage_event(int b, evt_kind_t k);
		if (have_staged)
			events_due.push_back(staged);
		staged.idx = b[IDX_W-1:0];
		staged.kind = k;
		staged.count = clicks[b];
		staged.last = 1'b0;
		have_staged = 1'b1;
	endfunction

	function automatic void classify_pass(logic [TW-1:0] now, logic [NB-1:0] pins,
		logic [NB-1:0] lock);
		logic [TW-1:0] held;
		logic [TW-1:0] gap;
		have_staged = 1'b0;
		for (int b = 0; b < NB; b++) begin
			if (!en_mask[b])
				continue;
			if (lock[b]) begin
				clear_seq(b);
				level[b] = 1'b1;
				continue;
			end
			// expired sequence goes out before the pin is looked at
			if (deadline[b] != '0 && now > deadline[b]) begin
				stage_event(b, EVT_SEQUENCE);
				clear_seq(b);
			end
			if (pins[b] == level[b])
				continue;
			level[b] = pins[b];
			if (!pins[b]) begin
				deadline[b] = '0;
				press_t[b] = now;
			end else begin
				held = now - press_t[b];
				if (held < {{(TW-PAR_W){1'b0}}, long_min}) begin
					deadline[b] = now + {{(TW-PAR_W){1'b0}}, seq_tmo};
					if (clicks[b] == '0)
						last_rel[b] = now;
					gap = now - last_rel[b];
					if (gap > {{(TW-PAR_W){1'b0}}, gap_max})
						clicks[b] = 8'd1;
					else
						clicks[b] = clicks[b] + 8'd1;
					last_rel[b] = now;
				end else begin
					stage_event(b, EVT_LONG);
					clear_seq(b);
				end
			end
		end
		if (have_staged) begin
			staged.last = 1'b1;
			events_due.push_back(staged);
			have_staged = 1'b0;
		end
	endfunction

	task automatic push_poll(input logic [TW-1:0] t, input logic [NB-1:0] pins,
		input logic [NB-1:0] lock);
		poll_t p;
		p.t = t;
		p.pins = pins;
		p.lock = lock;
		polls_q.push_back(p);
		stim_t = t;
		stim_pins = pins;
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= r;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(r, d);
	endtask

	task automatic set_regs(input logic [NB-1:0] en, input logic [PAR_W-1:0] lmin,
		input logic [PAR_W-1:0] gmax, input logic [PAR_W-1:0] tmo);
		write_reg(REG_ENABLED, CFG_DATA_W'(en));
		write_reg(REG_LONG_MIN, CFG_DATA_W'(lmin));
		write_reg(REG_GAP_MAX, CFG_DATA_W'(gmax));
		write_reg(REG_TIMEOUT, CFG_DATA_W'(tmo));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (polls_q.size() != 0 || in_ch.valid || events_due.size() != 0)
			@(posedge clk);
		// silent passes may still be in flight
		repeat (SETTLE) @(posedge clk);
	endtask

	// sparse pin toggles per pass give click runs and long holds at random tempo
	task automatic random_polls(input int n, input int unsigned scale);
		int unsigned r;
		logic [NB-1:0] lk;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				stim_t += $urandom_range(0, scale / 8 + 1);
			else if (r < 90)
				stim_t += $urandom_range(scale / 8, scale * 2 + 2);
			else if (r < 97)
				stim_t += $urandom_range(0, 2);
			else
				stim_t += $urandom;
			r = $urandom_range(0, 99);
			if (r < 8)
				stim_pins = NB'($urandom);
			else
				stim_pins ^= NB'($urandom & $urandom);
			r = $urandom_range(0, 99);
			if (r < 85)
				lk = '0;
			else if (r < 97)
				lk = NB'($urandom & $urandom & $urandom);
			else
				lk = NB'($urandom);
			push_poll(stim_t, stim_pins, lk);
		end
	endtask

	// long click runs: 50 on the upper half, 52 on the lower half
	task automatic click_storm();
		push_poll(stim_t + 1, '1, '1);
		push_poll(stim_t + 1, '1, '0);
		repeat (100) push_poll(stim_t + $urandom_range(1, 3), ~stim_pins, '0);
		repeat (4) push_poll(stim_t + $urandom_range(1, 3), stim_pins ^ 24'h000FFF, '0);
		push_poll(stim_t + 70000, stim_pins, '0);
	endtask

	task automatic directed_polls();
		push_poll(32'd0, 24'hFFFFFF, '0);
		push_poll(32'd10, 24'h000000, '0);
		push_poll(32'd50, 24'hFFF000, '0);
		push_poll(32'd100, 24'h000000, '0);
		push_poll(32'd150, 24'hFFF000, '0);
		// upper half held since 10: long presses
		push_poll(32'd700, 24'hFFFFFF, '0);
		// lower half sequences of two expire
		push_poll(32'd1200, 24'hFFFFFF, '0);
		// click then long press on button 0 reports the earlier click
		push_poll(32'd1300, 24'hFFFFFE, '0);
		push_poll(32'd1310, 24'hFFFFFF, '0);
		push_poll(32'd1320, 24'hFFFFFE, '0);
		push_poll(32'd1800, 24'hFFFFFF, '0);
		// button 3: wide gap restarts the count, narrow gap continues it
		push_poll(32'd3000, 24'hFFFFF7, '0);
		push_poll(32'd3010, 24'hFFFFFF, '0);
		push_poll(32'd3400, 24'hFFFFF7, '0);
		push_poll(32'd3410, 24'hFFFFFF, '0);
		push_poll(32'd3500, 24'hFFFFF7, '0);
		push_poll(32'd3510, 24'hFFFFFF, '0);
		// lock kills button 3's pending report and button 4's press
		push_poll(32'd3600, 24'hFFFFEF, '0);
		push_poll(32'd3700, 24'hFFFFEF, 24'h000018);
		push_poll(32'd5000, 24'hFFFFFF, '0);
		// button 1 short release whose deadline wraps to zero: never reported
		push_poll(32'hFFFFFB00, 24'hFFFFFD, '0);
		push_poll(32'hFFFFFC18, 24'hFFFFFF, '0);
		push_poll(32'hFFFFFFFF, 24'hFFFFFF, '0);
		push_poll(32'hFFFFFFFF, 24'h000000, 24'hFFFFFF);
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.time_now = '0;
		in_ch.pin_levels = '1;
		in_ch.lock_mask = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ENABLED;
		cfg_ch.data = '0;
		en_mask = '0;
		long_min = LONG_MIN_RST;
		gap_max = GAP_MAX_RST;
		seq_tmo = TIMEOUT_RST;
		for (int b = 0; b < NB; b++) begin
			level[b] = 1'b1;
			press_t[b] = '0;
			last_rel[b] = '0;
			deadline[b] = '0;
			clicks[b] = '0;
		end
		stim_t = '0;
		stim_pins = '1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_regs(24'hFFFFFF, 16'd400, 16'd300, 16'd1000);
		directed_polls();
		wait_idle();

		set_regs(24'hFFFFFF, 16'd400, 16'd500, 16'd500);
		random_polls(40, 600);
		wait_idle();

		set_regs(NB'($urandom), 16'd1, 16'd0, 16'd0);
		random_polls(30, 8);
		wait_idle();

		set_regs(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_polls(30, 65535);
		click_storm();
		wait_idle();

		// zero threshold: every press is long
		set_regs(NB'($urandom), 16'd0, PAR_W'($urandom), PAR_W'($urandom));
		random_polls(25, 300);
		wait_idle();

		set_regs(24'h000000, 16'd400, 16'd500, 16'd500);
		random_polls(10, 600);
		wait_idle();

		set_regs(NB'($urandom), PAR_W'($urandom_range(1, 2000)),
			PAR_W'($urandom_range(0, 3000)), PAR_W'($urandom_range(0, 3000)));
		random_polls(55, 32'(long_min));
		wait_idle();

		if (errors == 0 && events_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// sender: bursts of random length separated by random gaps
	always @(negedge clk) begin
		if (arst_n && (!in_ch.valid || in_acc)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (polls_q.size() > 0) begin
				nxt_poll = polls_q.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.time_now <= nxt_poll.t;
				in_ch.pin_levels <= nxt_poll.pins;
				in_ch.lock_mask <= nxt_poll.lock;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 15);
					case ($urandom_range(0, 19))
						0, 1, 2, 3, 4: gap_left = 0;
						5, 6, 7:       gap_left = $urandom_range(5, 25);
						default:       gap_left = $urandom_range(1, 4);
					endcase
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: ready follows one of four stall patterns, redrawn at random
	always @(negedge clk) begin
		stall_cyc++;
		if (stall_cyc % 97 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0:       out_ch.ready <= 1'b1;
			1:       out_ch.ready <= (stall_cyc % 4 != 0);
			2:       out_ch.ready <= 1'($urandom_range(0, 1));
			default: out_ch.ready <= (stall_cyc % 16 < 3);
		endcase
	end

	always @(posedge clk) begin
		in_acc = arst_n && in_ch.valid && in_ch.ready;
		out_acc = arst_n && out_ch.valid && out_ch.ready;
		if (in_acc)
			classify_pass(in_ch.time_now, in_ch.pin_levels, in_ch.lock_mask);
		if (out_acc) begin
			if (events_due.size() == 0) begin
				$display("%0t: unexpected item: btn %0d kind %0d count %0d last %0d",
					$time, out_ch.button_index, out_ch.event_kind, out_ch.click_count,
					out_ch.last_event);
				errors++;
			end else begin
				want = events_due.pop_front();
				if (out_ch.button_index !== want.idx || out_ch.event_kind !== want.kind ||
					out_ch.click_count !== want.count || out_ch.last_event !== want.last) begin
					$display("%0t: mismatch: expected btn %0d kind %0d count %0d last %0d",
						$time, want.idx, want.kind, want.count, want.last);
					$display("%0t:           actual   btn %0d kind %0d count %0d last %0d",
						$time, out_ch.button_index, out_ch.event_kind, out_ch.click_count,
						out_ch.last_event);
					errors++;
				end
			end
		end
		if (in_acc || out_acc || (cfg_ch.valid && cfg_ch.ready) || !arst_n)
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_MAX) begin
			$display("%0t: no item moved for %0d cycles", $time, quiet);
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule

### filelist.f
rtl/bcc_pkg.sv
rtl/bcc_if.sv
rtl/bcc_lane.sv
rtl/bcc_merge.sv
rtl/button_click_classifier_unit.sv
rtl/bcc_check.sv
dv/testbench.sv
